[rtl/arct_pkg.sv]
// Shared types, constants, rate tables and the control store for the
// adaptive rate cron tick block. No dependencies.
package arct_pkg;

  localparam int CNT_W    = 48;  // state counter width, wraps
  localparam int OUT_W    = 48;  // width of the running totals on the result
  localparam int CLIENT_W = 24;
  localparam int HZ_W     = 9;
  localparam int LEN_W    = 7;
  localparam int LVL_W    = 3;
  localparam int SPAN_W   = 9;
  localparam int NUM_LVL  = 7;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 168; // 162 bits of fields, padded to bytes

  localparam logic [LVL_W-1:0] LVL_BASE = 3'd0;
  localparam logic [LVL_W-1:0] LVL_CAP  = 3'd6;  // 500 Hz, no more doubling

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RATE,
    ST_COMMIT
  } step_t;

  typedef enum logic [1:0] {
    CD_IN_VALID,
    CD_RATE_DONE,
    CD_OUT_FREE
  } cond_t;

  // one control word: datapath strobes, jump condition and jump target
  typedef struct packed {
    logic  load_in;
    logic  step_rate;
    logic  commit;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic rate_done;
    logic out_free;
  } dp_status_t;

  // control store: stay on a step until its condition holds, then jump
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{load_in: 1'b0, step_rate: 1'b0, commit: 1'b0,
          cond: CD_IN_VALID, target: ST_IDLE};
    case (s)
      ST_IDLE:   begin
        w.load_in = 1'b1;
        w.cond    = CD_IN_VALID;
        w.target  = ST_RATE;
      end
      ST_RATE:   begin
        w.step_rate = 1'b1;
        w.cond      = CD_RATE_DONE;
        w.target    = ST_COMMIT;
      end
      ST_COMMIT: begin
        w.commit = 1'b1;
        w.cond   = CD_OUT_FREE;
        w.target = ST_IDLE;
      end
      default:   begin
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [HZ_W-1:0] rate_hz(input logic [LVL_W-1:0] l);
    case (l)
      3'd0:    return 9'd10;
      3'd1:    return 9'd20;
      3'd2:    return 9'd40;
      3'd3:    return 9'd80;
      3'd4:    return 9'd160;
      3'd5:    return 9'd320;
      default: return 9'd500;
    endcase
  endfunction

  // clients / hz > 200  <=>  clients >= 201 * hz
  function automatic logic [CLIENT_W-1:0] dbl_thr(input logic [LVL_W-1:0] l);
    case (l)
      3'd0:    return 24'd2010;
      3'd1:    return 24'd4020;
      3'd2:    return 24'd8040;
      3'd3:    return 24'd16080;
      3'd4:    return 24'd32160;
      3'd5:    return 24'd64320;
      default: return 24'd100500;
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] tick_len(input logic [LVL_W-1:0] l);
    case (l)
      3'd0:    return 7'd100;
      3'd1:    return 7'd50;
      3'd2:    return 7'd25;
      3'd3:    return 7'd12;
      3'd4:    return 7'd6;
      3'd5:    return 7'd3;
      default: return 7'd2;
    endcase
  endfunction

  // ticks per 100 ms task period, at least one
  function automatic logic [SPAN_W-1:0] span_100(input logic [LVL_W-1:0] l);
    case (l)
      3'd0:    return 9'd1;
      3'd1:    return 9'd2;
      3'd2:    return 9'd4;
      3'd3:    return 9'd8;
      3'd4:    return 9'd16;
      3'd5:    return 9'd32;
      default: return 9'd50;
    endcase
  endfunction

  // ticks per one second task period
  function automatic logic [SPAN_W-1:0] span_1s(input logic [LVL_W-1:0] l);
    return rate_hz(l);
  endfunction

endpackage

[rtl/arct_seq.sv]
// Microcode sequencer: step counter plus control store lookup.
// Depends on arct_pkg.
module arct_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  arct_pkg::dp_status_t status,
  output arct_pkg::uword_t    uw
);

  arct_pkg::step_t step, step_next;
  logic            take;

  always_comb begin
    uw = arct_pkg::ucode(step);
    case (uw.cond)
      arct_pkg::CD_IN_VALID:  take = in_valid;
      arct_pkg::CD_RATE_DONE: take = status.rate_done;
      arct_pkg::CD_OUT_FREE:  take = status.out_free;
      default:                take = 1'b1;
    endcase
    step_next = take ? uw.target : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= arct_pkg::ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[rtl/arct_dp.sv]
// Datapath: rate level search, per-level period residues, counters and
// the result register. Driven by control words from arct_seq; uses arct_pkg.
module arct_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  arct_pkg::uword_t                   uw,
  input  logic                               in_valid,
  input  logic [arct_pkg::CLIENT_W-1:0]      client_count,
  input  logic                               cfg_we,
  input  logic                               cfg_wdata,
  input  logic                               out_ready,
  output arct_pkg::dp_status_t               status,
  output logic                               out_valid,
  output logic [arct_pkg::HZ_W-1:0]          tick_rate_hz,
  output logic                               fired_100ms,
  output logic                               fired_1s,
  output logic [arct_pkg::LEN_W-1:0]         tick_length_ms,
  output logic [arct_pkg::OUT_W-1:0]         runs_100ms_total,
  output logic [arct_pkg::OUT_W-1:0]         runs_1s_total,
  output logic [arct_pkg::OUT_W-1:0]         elapsed_ms_total
);

  localparam int CW = arct_pkg::CNT_W;
  localparam int OW = arct_pkg::OUT_W;
  localparam int SW = arct_pkg::SPAN_W;
  localparam int NL = arct_pkg::NUM_LVL;

  logic                          adapt_enable;
  logic [arct_pkg::CLIENT_W-1:0] clients;
  logic [arct_pkg::LVL_W-1:0]    level;
  logic [CW-1:0]                 loop_count, count_100ms, count_1s, elapsed_ms;
  logic [CW-1:0]                 c100_next, c1s_next, elapsed_next;
  logic [SW-1:0]                 res100 [NL];
  logic [SW-1:0]                 res1s  [NL];
  logic                          doubling, commit_go, loop_wrap, f100, f1s;
  logic [arct_pkg::LEN_W-1:0]    len;

  assign doubling = adapt_enable && (level != arct_pkg::LVL_CAP) &&
                    (clients >= arct_pkg::dbl_thr(level));
  assign status.rate_done = !doubling;
  assign status.out_free  = !out_valid || out_ready;
  assign commit_go        = uw.commit && status.out_free;

  assign loop_wrap    = &loop_count;
  assign f100         = (res100[level] == '0);
  assign f1s          = (res1s[level] == '0);
  assign len          = arct_pkg::tick_len(level);
  assign c100_next    = count_100ms + CW'(f100);
  assign c1s_next     = count_1s + CW'(f1s);
  assign elapsed_next = elapsed_ms + CW'(len);

  always_ff @(posedge clk) begin
    if (rst) begin
      adapt_enable <= 1'b0;
    end else if (cfg_we) begin
      adapt_enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.load_in && in_valid) begin
      clients <= client_count;
      level   <= arct_pkg::LVL_BASE;
    end else if (uw.step_rate && doubling) begin
      level <= level + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_count  <= '0;
      count_100ms <= '0;
      count_1s    <= '0;
      elapsed_ms  <= '0;
    end else if (commit_go) begin
      loop_count  <= loop_count + 1'b1;
      count_100ms <= c100_next;
      count_1s    <= c1s_next;
      elapsed_ms  <= elapsed_next;
    end
  end

  // loop_count mod span, kept per level; all reset to zero with the count
  for (genvar i = 0; i < NL; i++) begin : g_res
    always_ff @(posedge clk) begin
      if (rst) begin
        res100[i] <= '0;
        res1s[i]  <= '0;
      end else if (commit_go) begin
        if (loop_wrap ||
            res100[i] == arct_pkg::span_100(arct_pkg::LVL_W'(i)) - 1'b1) begin
          res100[i] <= '0;
        end else begin
          res100[i] <= res100[i] + 1'b1;
        end
        if (loop_wrap ||
            res1s[i] == arct_pkg::span_1s(arct_pkg::LVL_W'(i)) - 1'b1) begin
          res1s[i] <= '0;
        end else begin
          res1s[i] <= res1s[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      tick_rate_hz     <= arct_pkg::rate_hz(level);
      fired_100ms      <= f100;
      fired_1s         <= f1s;
      tick_length_ms   <= len;
      runs_100ms_total <= OW'({{OW{1'b0}}, c100_next});
      runs_1s_total    <= OW'({{OW{1'b0}}, c1s_next});
      elapsed_ms_total <= OW'({{OW{1'b0}}, elapsed_next});
    end
  end

endmodule

[rtl/adaptive_rate_cron_tick_top.sv]
// Top level of the adaptive rate cron tick block: stream ports, config
// register port, sequencer and datapath. Depends on arct_pkg, arct_seq, arct_dp.
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       client_count
//  m_axis    out        m_axis_tvalid/tready       rate, fire flags, length, totals
//  cfg       in         cfg_we (no wait)           adapt_enable
//
// The level search in the microcode loop raises the rate level one step per
// cycle, for d = number of rate doublings (0..6); the next request is taken
// in the cycle after commit.
// Reset (rst, synchronous) clears the step counter, counters, residues,
// adapt_enable and the output valid. A stalled result holds in the output
// register; the block takes the next request meanwhile and waits in the
// commit step only if that request finishes before the old result leaves.
module adaptive_rate_cron_tick_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [23:0] client_count
  input  logic [arct_pkg::IN_DW-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [8:0] tick_rate_hz, [9] fired_100ms, [10] fired_1s, [17:11] tick_length_ms,
  // [65:18] runs_100ms_total, [113:66] runs_1s_total,
  // [161:114] elapsed_ms_total, [167:162] zero
  output logic [arct_pkg::OUT_DW-1:0]   m_axis_tdata,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata
);

  arct_pkg::uword_t     uw;
  arct_pkg::dp_status_t status;

  logic [arct_pkg::HZ_W-1:0]  tick_rate_hz;
  logic                       fired_100ms;
  logic                       fired_1s;
  logic [arct_pkg::LEN_W-1:0] tick_length_ms;
  logic [arct_pkg::OUT_W-1:0] runs_100ms_total;
  logic [arct_pkg::OUT_W-1:0] runs_1s_total;
  logic [arct_pkg::OUT_W-1:0] elapsed_ms_total;

  // the idle step is the only one that takes a request
  assign s_axis_tready = uw.load_in;

  arct_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .status   (status),
    .uw       (uw)
  );

  arct_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .uw               (uw),
    .in_valid         (s_axis_tvalid),
    .client_count     (s_axis_tdata[arct_pkg::CLIENT_W-1:0]),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_ready        (m_axis_tready),
    .status           (status),
    .out_valid        (m_axis_tvalid),
    .tick_rate_hz     (tick_rate_hz),
    .fired_100ms      (fired_100ms),
    .fired_1s         (fired_1s),
    .tick_length_ms   (tick_length_ms),
    .runs_100ms_total (runs_100ms_total),
    .runs_1s_total    (runs_1s_total),
    .elapsed_ms_total (elapsed_ms_total)
  );

  // pack result fields, first field at bit 0
  assign m_axis_tdata = {6'd0, elapsed_ms_total, runs_1s_total, runs_100ms_total,
                         tick_length_ms, fired_1s, fired_100ms, tick_rate_hz};

endmodule
